/* rtl/core/bapf_pkg.sv */
// Shared types and constants for the advertising prefix filter.
// No dependencies; imported by every module of the block.
package bapf_pkg;

  localparam int MAX_PAYLOAD  = 37;
  localparam int HARD_MAX_LEN = 37;
  localparam int LEN_UPPER_I  = (MAX_PAYLOAD < HARD_MAX_LEN) ? MAX_PAYLOAD : HARD_MAX_LEN;

  localparam int DATA_DEPTH = 31;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);

  localparam logic [7:0] MIN_LEN   = 8'd6;
  localparam logic [7:0] LEN_UPPER = LEN_UPPER_I[7:0];
  localparam int         TXADD_BIT = 6;

  localparam logic [5:0] POS_HEADER     = 6'd0;
  localparam logic [5:0] POS_LENGTH     = 6'd1;
  localparam logic [5:0] POS_ADDR_FIRST = 6'd2;
  localparam logic [5:0] POS_DATA_FIRST = 6'd8;
  localparam logic [5:0] POS_DATA_END   = POS_DATA_FIRST + DATA_DEPTH[5:0];
  localparam logic [5:0] POS_MAX        = 6'd63;

  localparam logic [23:0] VENDOR_PREFIX_RESET = 24'h78818C;
  localparam logic [15:0] TYPE_MASK_RESET     = 16'h0045;

  localparam logic CFG_VENDOR_PREFIX = 1'b0;
  localparam logic CFG_TYPE_MASK     = 1'b1;

  localparam logic CMD_PACKET_BYTE = 1'b0;
  localparam logic CMD_CLEAR       = 1'b1;

  localparam logic ITEM_STATUS = 1'b0;
  localparam logic ITEM_DATA   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_CRC_ERROR = 2'd0,
    VERDICT_LOCKED    = 2'd1,
    VERDICT_REJECTED  = 2'd2,
    VERDICT_MATCHED   = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t verdict;
    logic     match;
  } check_res_t;

endpackage

/* rtl/core/bapf_frame_check.sv */
// Packet acceptance check for the advertising prefix filter.
// Depends on bapf_pkg for the verdict type and length limits.
module bapf_frame_check
  import bapf_pkg::*;
(
  input  logic [7:0]  header,
  input  logic [7:0]  length,
  input  logic [5:0]  position,
  input  logic [47:0] address,
  input  logic [23:0] prefix,
  input  logic [15:0] type_mask,
  input  logic        crc_good,
  input  logic        locked,
  output check_res_t  res
);

  logic [8:0] need_pos;
  logic       accept_pkt;

  always_comb begin
    need_pos   = {1'b0, length} + 9'd2;
    accept_pkt = type_mask[header[3:0]]
                 && (length >= MIN_LEN) && (length <= LEN_UPPER)
                 && !header[TXADD_BIT]
                 && ({3'b000, position} >= need_pos)
                 && (address[47:24] == prefix);
    priority if (!crc_good) begin
      res.verdict = VERDICT_CRC_ERROR;
    end else if (locked) begin
      res.verdict = VERDICT_LOCKED;
    end else if (accept_pkt) begin
      res.verdict = VERDICT_MATCHED;
    end else begin
      res.verdict = VERDICT_REJECTED;
    end
    res.match = (res.verdict == VERDICT_MATCHED);
  end

endmodule

/* rtl/core/ble_adv_prefix_filter_unit.sv */
// Top level of the advertising prefix filter: packet assembly, data store, output register.
// Depends on bapf_pkg and bapf_frame_check.
//
// Usage: the receiver side pushes PDU bytes as requests on the in_ channel,
// header first, then length, then payload, with in_byte_last and in_crc_good
// on the final byte. A request with in_command set clears the counters, the
// lock and the capture and starts a new session; it produces no result.
// Configuration (vendor prefix, accepted PDU type mask) is written through
// the cfg_ channel, which is always ready, while the block is idle.
// Every ended packet yields one status request on the out_ channel, in the cycle
// after its final byte is accepted. The first matching packet of a session
// is followed by its advertising data bytes, one per cycle while the receiver
// keeps taking them, read in turn from the on-chip data store; during that run
// the input is held off. Throughput is one byte per cycle otherwise, set by
// the single output register: a byte is taken whenever that register is empty
// or being emptied. When the receiver stalls, the result waits in the output
// register and input is held off until it is taken.
// Reset (synchronous, rst_n low) clears counters, lock, capture and the
// packet in progress and restores the register defaults; the data store
// needs no clearing, since only bytes of the current packet are ever read.
module ble_adv_prefix_filter_unit
  import bapf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_byte_last,
  input  logic        in_crc_good,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_packets_seen,
  output logic [31:0] out_packets_crc_ok,
  output logic [31:0] out_packets_matched,
  output logic        out_locked,
  output logic [47:0] out_peer_address,
  output logic [4:0]  out_peer_data_length,
  output logic [7:0]  out_data_value,
  output logic        out_run_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  // Configuration registers
  logic [23:0] prefix_r;
  logic [15:0] type_mask_r;

  // Packet being assembled
  logic [5:0]  pos_r, pos_asm, pos_nxt;
  logic [7:0]  hdr_r, hdr_asm, hdr_nxt;
  logic [7:0]  len_r, len_asm, len_nxt;
  logic [47:0] addr_r, addr_asm, addr_nxt;
  logic [2:0]  addr_slot;

  // Session state
  logic [47:0] cap_addr_r, cap_addr_nxt;
  logic [4:0]  cap_len_r, cap_len_nxt;
  logic        lock_r, lock_nxt;
  logic [31:0] cnt_total_r, cnt_total_nxt;
  logic [31:0] cnt_crc_r, cnt_crc_nxt;
  logic [31:0] cnt_match_r, cnt_match_nxt;

  // Data run after a match
  logic               drain_r, drain_nxt;
  logic [DATA_AW-1:0] rd_idx_r, rd_idx_nxt;

  // Data store, one write port and one registered read port
  logic [7:0]         mem [DATA_DEPTH];
  logic               mem_we;
  logic [5:0]         mem_off;
  logic [DATA_AW-1:0] mem_waddr;
  logic [7:0]         rd_data_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  verdict_t    out_verdict_r, out_verdict_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_free;

  logic        accept, byte_acc, clr_acc, end_pkt, data_load;
  logic [4:0]  new_cap_len;
  check_res_t  chk;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !drain_r && out_free;
  assign accept    = in_valid && in_ready;
  assign byte_acc  = accept && (in_command == CMD_PACKET_BYTE);
  assign clr_acc   = accept && (in_command == CMD_CLEAR);
  assign end_pkt   = byte_acc && in_byte_last;
  assign data_load = drain_r && out_free;

  // The check sees the packet including the byte that ends it.
  bapf_frame_check u_check (
    .header    (hdr_asm),
    .length    (len_asm),
    .position  (pos_asm),
    .address   (addr_asm),
    .prefix    (prefix_r),
    .type_mask (type_mask_r),
    .crc_good  (in_crc_good),
    .locked    (lock_r),
    .res       (chk)
  );

  // Byte assembly: header, length, six address bytes, then the data store.
  always_comb begin
    hdr_asm   = hdr_r;
    len_asm   = len_r;
    addr_asm  = addr_r;
    pos_asm   = pos_r;
    mem_we    = 1'b0;
    mem_off   = pos_r - POS_DATA_FIRST;
    mem_waddr = mem_off[DATA_AW-1:0];
    addr_slot = pos_r[2:0] - POS_ADDR_FIRST[2:0];
    if (byte_acc) begin
      priority if (pos_r == POS_HEADER) begin
        hdr_asm = in_rx_byte;
      end else if (pos_r == POS_LENGTH) begin
        len_asm = in_rx_byte;
      end else if (pos_r < POS_DATA_FIRST) begin
        addr_asm[{addr_slot, 3'b000} +: 8] = in_rx_byte;
      end else if (pos_r < POS_DATA_END) begin
        mem_we = 1'b1;
      end else begin
        // Bytes past the store are counted in the position only.
        mem_we = 1'b0;
      end
      if (pos_r < POS_MAX) begin
        pos_asm = pos_r + 6'd1;
      end
    end
  end

  // Session bookkeeping, data run and output register loading.
  always_comb begin
    new_cap_len     = len_asm[4:0] - MIN_LEN[4:0];
    hdr_nxt         = hdr_asm;
    len_nxt         = len_asm;
    addr_nxt        = addr_asm;
    pos_nxt         = pos_asm;
    cap_addr_nxt    = cap_addr_r;
    cap_len_nxt     = cap_len_r;
    lock_nxt        = lock_r;
    cnt_total_nxt   = cnt_total_r;
    cnt_crc_nxt     = cnt_crc_r;
    cnt_match_nxt   = cnt_match_r;
    drain_nxt       = drain_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_verdict_nxt = out_verdict_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;

    if (clr_acc) begin
      hdr_nxt       = '0;
      len_nxt       = '0;
      addr_nxt      = '0;
      pos_nxt       = '0;
      cap_addr_nxt  = '0;
      cap_len_nxt   = '0;
      lock_nxt      = 1'b0;
      cnt_total_nxt = '0;
      cnt_crc_nxt   = '0;
      cnt_match_nxt = '0;
    end

    if (end_pkt) begin
      hdr_nxt         = '0;
      len_nxt         = '0;
      addr_nxt        = '0;
      pos_nxt         = '0;
      cnt_total_nxt   = cnt_total_r + 32'd1;
      if (in_crc_good) begin
        cnt_crc_nxt = cnt_crc_r + 32'd1;
      end
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = ITEM_STATUS;
      out_verdict_nxt = chk.verdict;
      out_data_nxt    = '0;
      out_last_nxt    = 1'b1;
      if (chk.match) begin
        cnt_match_nxt = cnt_match_r + 32'd1;
        lock_nxt      = 1'b1;
        cap_addr_nxt  = addr_asm;
        cap_len_nxt   = new_cap_len;
        out_last_nxt  = (new_cap_len == 5'd0);
        drain_nxt     = (new_cap_len != 5'd0);
        rd_idx_nxt    = '0;
      end
    end else if (data_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = ITEM_DATA;
      out_data_nxt  = rd_data_r;
      if ({1'b0, rd_idx_r} == {1'b0, cap_len_r} - 6'd1) begin
        out_last_nxt = 1'b1;
        drain_nxt    = 1'b0;
        rd_idx_nxt   = '0;
      end else begin
        out_last_nxt = 1'b0;
        rd_idx_nxt   = rd_idx_r + 1'b1;
      end
    end
  end

  // The read address follows the next data index, so rd_data_r always holds
  // the entry under rd_idx_r. A write to the same entry is forwarded.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_rx_byte;
    end
    if (mem_we && (mem_waddr == rd_idx_nxt)) begin
      rd_data_r <= in_rx_byte;
    end else begin
      rd_data_r <= mem[rd_idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= VENDOR_PREFIX_RESET;
      type_mask_r <= TYPE_MASK_RESET;
      pos_r       <= '0;
      hdr_r       <= '0;
      len_r       <= '0;
      addr_r      <= '0;
      cap_addr_r  <= '0;
      cap_len_r   <= '0;
      lock_r      <= 1'b0;
      cnt_total_r <= '0;
      cnt_crc_r   <= '0;
      cnt_match_r <= '0;
      drain_r     <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_VENDOR_PREFIX: prefix_r    <= cfg_data;
          CFG_TYPE_MASK:     type_mask_r <= cfg_data[15:0];
          default:           prefix_r    <= prefix_r;
        endcase
      end
      pos_r       <= pos_nxt;
      hdr_r       <= hdr_nxt;
      len_r       <= len_nxt;
      addr_r      <= addr_nxt;
      cap_addr_r  <= cap_addr_nxt;
      cap_len_r   <= cap_len_nxt;
      lock_r      <= lock_nxt;
      cnt_total_r <= cnt_total_nxt;
      cnt_crc_r   <= cnt_crc_nxt;
      cnt_match_r <= cnt_match_nxt;
      drain_r     <= drain_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload; the status fields are sampled when a status item loads.
  logic [31:0] o_seen_r, o_crc_r, o_match_r;
  logic        o_lock_r;
  logic [47:0] o_addr_r;
  logic [4:0]  o_len_r;

  always_ff @(posedge clk) begin
    out_kind_r    <= out_kind_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_data_r    <= out_data_nxt;
    out_last_r    <= out_last_nxt;
    if (end_pkt) begin
      o_seen_r  <= cnt_total_nxt;
      o_crc_r   <= cnt_crc_nxt;
      o_match_r <= cnt_match_nxt;
      o_lock_r  <= lock_nxt;
      o_addr_r  <= cap_addr_nxt;
      o_len_r   <= cap_len_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item_kind        = out_kind_r;
  assign out_verdict          = out_verdict_r;
  assign out_packets_seen     = o_seen_r;
  assign out_packets_crc_ok   = o_crc_r;
  assign out_packets_matched  = o_match_r;
  assign out_locked           = o_lock_r;
  assign out_peer_address     = o_addr_r;
  assign out_peer_data_length = o_len_r;
  assign out_data_value       = out_data_r;
  assign out_run_last         = out_last_r;

endmodule

/* rtl/core/bapf_port_checker.sv */
// Port-level assertions for the advertising prefix filter, bound to the top level.
// Depends on bapf_pkg and ble_adv_prefix_filter_unit.
module bapf_port_checker
  import bapf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic [7:0]  in_rx_byte,
  input logic        in_byte_last,
  input logic        in_crc_good,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_item_kind,
  input logic [1:0]  out_verdict,
  input logic [31:0] out_packets_seen,
  input logic [31:0] out_packets_crc_ok,
  input logic [31:0] out_packets_matched,
  input logic        out_locked,
  input logic [47:0] out_peer_address,
  input logic [4:0]  out_peer_data_length,
  input logic [7:0]  out_data_value,
  input logic        out_run_last,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [23:0] cfg_data
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data_value)
                                   && $stable(out_item_kind) && $stable(out_run_last)))
    else $error("stalled result changed");

  // Within a run the next data byte is ready in the very next cycle.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_last) |=> (out_valid && out_item_kind == ITEM_DATA))
    else $error("data run broken");

  // Data bytes and match or locked verdicts only appear once locked.
  a_data_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item_kind == ITEM_DATA || out_verdict == VERDICT_MATCHED
                   || out_verdict == VERDICT_LOCKED)) |-> out_locked)
    else $error("match reported without lock");

  // Input is only taken when the output register can take a result.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_ready)
    else $error("input taken while result stalled");

endmodule

bind ble_adv_prefix_filter_unit bapf_port_checker u_port_checker (.*);

/* bench/ble_adv_prefix_filter_unit_tb.sv */
// Self-checking bench for ble_adv_prefix_filter_unit: directed and random PDU byte streams,
// with status and data reports predicted per request and compared on the out_ channel.
// Depends on bapf_pkg and the filter RTL only.
module ble_adv_prefix_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bapf_pkg::*;

  // Cycles with no request moving on any channel before the run is abandoned. The slowest
  // legitimate quiet spell is the long receiver hold-off, well below this.
  localparam int WATCHDOG_LIMIT = 2000;
  // A final byte of a matching packet keeps the block busy for its whole data run, so every
  // drain waits longer than such a run once the last report is in.
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 150;
  localparam int REPORT_LIMIT   = 10;

  // PDU type codes used by the directed part and the closing type mask.
  localparam logic [3:0] PDU_ADV_IND         = 4'd0;
  localparam logic [3:0] PDU_ADV_DIRECT_IND  = 4'd1;
  localparam logic [3:0] PDU_ADV_NONCONN_IND = 4'd2;
  localparam logic [3:0] PDU_ADV_SCAN_IND    = 4'd6;
  localparam logic [3:0] PDU_KIND_TOP        = 4'd15;

  // One request on the in_ channel.
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       last;
    logic       crc_good;
  } pdu_req_t;

  // One request on the out_ channel.
  typedef struct packed {
    logic        kind;
    verdict_t    verdict;
    logic [31:0] seen;
    logic [31:0] crc_ok;
    logic [31:0] matched;
    logic        locked;
    logic [47:0] address;
    logic [4:0]  peer_len;
    logic [7:0]  data;
    logic        run_last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_PACKET_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_byte_last = 1'b0;
  logic        in_crc_good = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_item_kind;
  logic [1:0]  out_verdict;
  logic [31:0] out_packets_seen;
  logic [31:0] out_packets_crc_ok;
  logic [31:0] out_packets_matched;
  logic        out_locked;
  logic [47:0] out_peer_address;
  logic [4:0]  out_peer_data_length;
  logic [7:0]  out_data_value;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_VENDOR_PREFIX;
  logic [23:0] cfg_data = 24'h000000;

  ble_adv_prefix_filter_unit u_dut (.*);

  // The bench clock: 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Requests still to be offered, and reports predicted but not yet seen.
  pdu_req_t pdu_byte_q[$];
  report_t  report_q[$];

  // Copy of the filter state, advanced once per accepted request.
  logic [5:0]  m_pos;
  logic [7:0]  m_header;
  logic [7:0]  m_length;
  logic [47:0] m_address;
  logic [7:0]  m_data [DATA_DEPTH];
  logic [47:0] m_peer;
  logic [4:0]  m_peer_len;
  logic        m_locked;
  logic [31:0] m_seen;
  logic [31:0] m_crc_ok;
  logic [31:0] m_matched;
  logic [23:0] m_prefix;
  logic [15:0] m_type_mask;

  // Register values that the stimulus generator aims at; they follow each write.
  logic [23:0] gen_prefix = VENDOR_PREFIX_RESET;
  logic [15:0] gen_mask = TYPE_MASK_RESET;

  // Flow control knobs, set per phase by the sequence below.
  int ready_stall_pct = 0;
  int send_gap_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int ready_gap = 0;
  int send_gap = 0;
  bit in_taken = 1'b0;

  // Bookkeeping for the summary and the verdict.
  int mismatches = 0;
  int quiet_cycles = 0;
  int requests_taken = 0;
  int reports_checked = 0;
  int n_clears = 0;
  int n_matches = 0;
  int n_writes = 0;
  int queued_bytes = 0;
  int queued_packets = 0;

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Forget the packet being assembled. The data store keeps its contents, as in hardware.
  task automatic drop_assembly();
    m_pos = POS_HEADER;
    m_header = 8'h00;
    m_length = 8'h00;
    m_address = '0;
  endtask

  // Counters, lock and capture go back to zero on reset and on a clear request.
  task automatic clear_session();
    m_peer = '0;
    m_peer_len = '0;
    m_locked = 1'b0;
    m_seen = '0;
    m_crc_ok = '0;
    m_matched = '0;
  endtask

  // The filter decision for a CRC-good packet while the session is still unlocked. The
  // position has already moved past the final byte, so it equals the bytes received
  // (or 63 once it has saturated).
  function automatic verdict_t judge_packet();
    if (!m_type_mask[m_header[3:0]]) return VERDICT_REJECTED;
    if (m_length < MIN_LEN || m_length > LEN_UPPER) return VERDICT_REJECTED;
    if (m_header[TXADD_BIT]) return VERDICT_REJECTED;
    if (int'(m_pos) < int'(m_length) + 2) return VERDICT_REJECTED;
    if (m_address[47:24] != m_prefix) return VERDICT_REJECTED;
    return VERDICT_MATCHED;
  endfunction

  // Advance the filter state by one accepted request and queue the reports it causes.
  task automatic follow_pdu_byte(input pdu_req_t r);
    report_t    rep;
    logic [5:0] pos;
    logic [7:0] len_gap;
    verdict_t   v;
    pos = m_pos;
    if (r.cmd == CMD_CLEAR) begin
      n_clears++;
      drop_assembly();
      clear_session();
      return;
    end
    // Header, length, six address bytes, then the advertising data; bytes past the store
    // are dropped, and the position sticks at its top value.
    if (pos == POS_HEADER) m_header = r.rx_byte;
    else if (pos == POS_LENGTH) m_length = r.rx_byte;
    else if (pos < POS_DATA_FIRST) m_address[(int'(pos) - 2) * 8 +: 8] = r.rx_byte;
    else if (pos < POS_DATA_END) m_data[pos - POS_DATA_FIRST] = r.rx_byte;
    if (pos != POS_MAX) m_pos = pos + 6'd1;
    if (!r.last) return;

    m_seen++;
    if (!r.crc_good) begin
      v = VERDICT_CRC_ERROR;
    end else begin
      m_crc_ok++;
      v = m_locked ? VERDICT_LOCKED : judge_packet();
    end
    if (v == VERDICT_MATCHED) begin
      n_matches++;
      m_matched++;
      m_locked = 1'b1;
      m_peer = m_address;
      len_gap = m_length - MIN_LEN;
      m_peer_len = len_gap[4:0];
    end

    // The status report carries the counters after this packet was counted.
    rep.kind = ITEM_STATUS;
    rep.verdict = v;
    rep.seen = m_seen;
    rep.crc_ok = m_crc_ok;
    rep.matched = m_matched;
    rep.locked = m_locked;
    rep.address = m_peer;
    rep.peer_len = m_peer_len;
    rep.data = 8'h00;
    rep.run_last = (v != VERDICT_MATCHED) || (m_peer_len == 5'd0);
    report_q.push_back(rep);
    // A match is followed by its data bytes, each repeating the status fields.
    if (v == VERDICT_MATCHED) begin
      for (int i = 0; i < m_peer_len; i++) begin
        rep.kind = ITEM_DATA;
        rep.data = m_data[i];
        rep.run_last = (i == m_peer_len - 1);
        report_q.push_back(rep);
      end
    end
    drop_assembly();
  endtask

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  function automatic string describe(input report_t r);
    return $sformatf({"kind=%0d verdict=%0d seen=%0d crc_ok=%0d matched=%0d locked=%0d",
                      " addr=%012h len=%0d data=%02h last=%0d"},
                     r.kind, r.verdict, r.seen, r.crc_ok, r.matched, r.locked,
                     r.address, r.peer_len, r.data, r.run_last);
  endfunction

  task automatic compare_report(input report_t want, input report_t got);
    string bad;
    bad = "";
    if (got.kind !== want.kind) bad = {bad, " item_kind"};
    if (got.verdict !== want.verdict) bad = {bad, " verdict"};
    if (got.seen !== want.seen) bad = {bad, " packets_seen"};
    if (got.crc_ok !== want.crc_ok) bad = {bad, " packets_crc_ok"};
    if (got.matched !== want.matched) bad = {bad, " packets_matched"};
    if (got.locked !== want.locked) bad = {bad, " locked"};
    if (got.address !== want.address) bad = {bad, " peer_address"};
    if (got.peer_len !== want.peer_len) bad = {bad, " peer_data_length"};
    if (got.data !== want.data) bad = {bad, " data_value"};
    if (got.run_last !== want.run_last) bad = {bad, " run_last"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("Mismatch at %0t on:%s", $time, bad);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endtask

  // The monitor samples all three channels at the rising edge. Reports are checked before
  // the input request of the same edge is predicted; a report can never belong to a
  // request accepted at the very same edge, since the block registers its output.
  always @(posedge clk) begin
    report_t  got;
    pdu_req_t req;
    bit       moved;
    in_taken = 1'b0;
    moved = 1'b0;
    if (!rst_n) begin
      // The predictor follows the synchronous reset of the block.
      m_prefix = VENDOR_PREFIX_RESET;
      m_type_mask = TYPE_MASK_RESET;
      drop_assembly();
      for (int i = 0; i < DATA_DEPTH; i++) m_data[i] = 8'h00;
      clear_session();
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        reports_checked++;
        got.kind = out_item_kind;
        got.verdict = verdict_t'(out_verdict);
        got.seen = out_packets_seen;
        got.crc_ok = out_packets_crc_ok;
        got.matched = out_packets_matched;
        got.locked = out_locked;
        got.address = out_peer_address;
        got.peer_len = out_peer_data_length;
        got.data = out_data_value;
        got.run_last = out_run_last;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Unexpected report at %0t: %s", $time, describe(got));
        end else begin
          compare_report(report_q.pop_front(), got);
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        in_taken = 1'b1;
        requests_taken++;
        req.cmd = in_command;
        req.rx_byte = in_rx_byte;
        req.last = in_byte_last;
        req.crc_good = in_crc_good;
        follow_pdu_byte(req);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        n_writes++;
        if (cfg_index == CFG_VENDOR_PREFIX) m_prefix = cfg_data;
        else m_type_mask = cfg_data[15:0];
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("ble_adv_prefix_filter_unit regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------------------

  // The sender presents the next queued request at the falling edge once the previous one
  // has gone, at times after a gap drawn per send_gap_pct. A request stays put until taken.
  always @(negedge clk) begin
    pdu_req_t nxt;
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pdu_byte_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(1, 100) <= send_gap_pct) begin
        send_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        nxt = pdu_byte_q.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.cmd;
        in_rx_byte <= nxt.rx_byte;
        in_byte_last <= nxt.last;
        in_crc_good <= nxt.crc_good;
      end
    end
  end

  // The receiver drops ready in random bursts, or for one long hold-off when the
  // sequence asks for it; the hold-off is counted here, independently of the sender.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(1, 100) <= ready_stall_pct) begin
      ready_gap = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  // Header byte with the given PDU type and TxAdd; RxAdd and the two middle bits random.
  function automatic logic [7:0] make_header(input logic [3:0] pdu_kind, input logic tx_add);
    logic [7:0] rnd;
    rnd = 8'($urandom);
    return {rnd[7], tx_add, rnd[5:4], pdu_kind};
  endfunction

  function automatic logic [47:0] make_address(input logic [23:0] prefix);
    return {prefix, 24'($urandom)};
  endfunction

  // A PDU type that the current mask accepts or, with accepted clear, rejects, if one can be found.
  function automatic logic [3:0] pick_kind(input bit accepted);
    logic [3:0] k;
    k = 4'($urandom);
    for (int n = 0; n < 32; n++) begin
      if (gen_mask[k] == accepted) return k;
      k = 4'($urandom);
    end
    return k;
  endfunction

  // A clear request; its byte, last and CRC fields are don't-cares and so are random.
  task automatic queue_clear();
    pdu_req_t r;
    r.cmd = CMD_CLEAR;
    r.rx_byte = 8'($urandom);
    r.last = 1'($urandom);
    r.crc_good = 1'($urandom);
    pdu_byte_q.push_back(r);
  endtask

  // A packet of n_bytes requests: header, length, address, then random payload. The CRC
  // flag only matters on the final byte, so elsewhere it is random.
  task automatic queue_packet(input logic [7:0] header, input logic [7:0] length,
                              input logic [47:0] address, input int n_bytes,
                              input logic crc);
    pdu_req_t r;
    for (int i = 0; i < n_bytes; i++) begin
      r.cmd = CMD_PACKET_BYTE;
      if (i == 0) r.rx_byte = header;
      else if (i == 1) r.rx_byte = length;
      else if (i < 8) r.rx_byte = address[(i - 2) * 8 +: 8];
      else r.rx_byte = 8'($urandom);
      r.last = (i == n_bytes - 1);
      r.crc_good = r.last ? crc : 1'($urandom);
      pdu_byte_q.push_back(r);
    end
    queued_bytes += n_bytes;
    queued_packets++;
  endtask

  // A packet cut off by a clear before its final byte.
  task automatic queue_abandoned(input int n_bytes);
    pdu_req_t r;
    for (int i = 0; i < n_bytes; i++) begin
      r.cmd = CMD_PACKET_BYTE;
      r.rx_byte = 8'($urandom);
      r.last = 1'b0;
      r.crc_good = 1'($urandom);
      pdu_byte_q.push_back(r);
    end
    queued_bytes += n_bytes;
    queue_clear();
  endtask

  // Mostly well-formed packets aimed at the current prefix and mask, a quarter of them with
  // a single flaw, and a quarter plain noise. Lengths are mostly short so that data runs
  // and the run as a whole stay brief.
  task automatic queue_random_packet();
    logic [7:0]  header;
    logic [7:0]  length;
    logic [47:0] address;
    logic [23:0] prefix;
    int          n_bytes;
    int          flaw;
    logic        crc;
    flaw = $urandom_range(0, 15);
    if (flaw >= 12) begin
      header = 8'($urandom);
      length = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      address = {16'($urandom), 32'($urandom)};
      queue_packet(header, length, address, $urandom_range(1, 10), 1'($urandom));
      return;
    end
    length = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(6, 37)) : 8'($urandom_range(6, 8));
    header = make_header(pick_kind(1'b1), 1'b0);
    prefix = gen_prefix;
    crc = 1'b1;
    n_bytes = int'(length) + 2;
    if ($urandom_range(0, 3) == 0) n_bytes += $urandom_range(1, 2);
    case (flaw)
      8: crc = 1'b0;
      9: n_bytes = $urandom_range(1, int'(length) + 1);
      10: prefix = gen_prefix ^ (24'd1 << $urandom_range(0, 23));
      11: begin
        case ($urandom_range(0, 2))
          0: header[TXADD_BIT] = 1'b1;
          1: begin
            length = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 5))
                                                 : 8'($urandom_range(38, 255));
            n_bytes = $urandom_range(8, 12);
          end
          default: header[3:0] = pick_kind(1'b0);
        endcase
      end
      default: ;
    endcase
    address = make_address(prefix);
    queue_packet(header, length, address, n_bytes, crc);
  endtask

  // Random traffic until both byte and packet budgets are spent. Clears keep reopening the
  // session so that later matches can still happen.
  task automatic run_random(input int min_bytes, input int min_packets);
    int start_bytes;
    int start_packets;
    int pick;
    start_bytes = queued_bytes;
    start_packets = queued_packets;
    while (queued_bytes - start_bytes < min_bytes ||
           queued_packets - start_packets < min_packets) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) queue_clear();
      else if (pick < 16) queue_abandoned($urandom_range(1, 4));
      else queue_random_packet();
    end
  endtask

  // Wait for the sender to run dry and every predicted report to arrive, then let the
  // block finish whatever request produced no report.
  task automatic wait_drain();
    @(posedge clk);
    while (pdu_byte_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VENDOR_PREFIX) gen_prefix = value;
    else gen_mask = value[15:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    // Reset is held low from the start and released on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, register defaults: each filter condition on its own, the lock, the
    // clear, and the packet shapes at the edges of the data store.
    ready_stall_pct = 20;
    send_gap_pct = 20;
    queue_clear();
    // First match of the session is the longest payload, running on past the store until
    // the position saturates: 31 data bytes follow, and the extra bytes change nothing.
    queue_packet(make_header(PDU_ADV_SCAN_IND, 1'b0), 8'd37, make_address(gen_prefix),
                 64, 1'b1);
    // While locked, single-byte packets with good and bad CRC.
    queue_packet(make_header(PDU_ADV_IND, 1'b0), 8'd6, make_address(gen_prefix), 1, 1'b1);
    queue_packet(make_header(PDU_ADV_IND, 1'b0), 8'd6, make_address(gen_prefix), 1, 1'b0);
    queue_clear();
    // Rejections: type outside the mask, TxAdd set, length just below range, prefix
    // off in its highest bit, one byte short.
    queue_packet(make_header(PDU_ADV_DIRECT_IND, 1'b0), 8'd6, make_address(gen_prefix),
                 8, 1'b1);
    queue_packet(make_header(PDU_ADV_IND, 1'b1), 8'd6, make_address(gen_prefix), 8, 1'b1);
    queue_packet(make_header(PDU_ADV_IND, 1'b0), 8'd5, make_address(gen_prefix), 7, 1'b1);
    queue_packet(make_header(PDU_ADV_IND, 1'b0), 8'd6,
                 make_address(gen_prefix ^ 24'h800000), 8, 1'b1);
    queue_packet(make_header(PDU_ADV_NONCONN_IND, 1'b0), 8'd6, make_address(gen_prefix),
                 7, 1'b1);
    // A half-received packet thrown away by a clear, then a match with no data bytes.
    queue_abandoned(2);
    queue_packet(make_header(PDU_ADV_IND, 1'b0), 8'd6, make_address(gen_prefix), 8, 1'b1);
    wait_drain();

    // Everything accepted and an all-ones prefix. The receiver holds off for a long
    // stretch at the start, so the block fills up and refuses input for a while.
    write_register(CFG_VENDOR_PREFIX, 24'hFFFFFF);
    write_register(CFG_TYPE_MASK, 24'h00FFFF);
    hold_request = LONG_HOLD;
    run_random(1, 2);
    wait_drain();

    // Nothing accepted and a zero prefix; the sender then waits for every outstanding
    // report before carrying on.
    write_register(CFG_VENDOR_PREFIX, 24'h000000);
    write_register(CFG_TYPE_MASK, 24'h000000);
    run_random(1, 1);
    wait_drain();

    // Random settings, heavy receiver back-pressure, a nearly continuous sender.
    ready_stall_pct = 50;
    send_gap_pct = 5;
    write_register(CFG_VENDOR_PREFIX, 24'($urandom));
    write_register(CFG_TYPE_MASK, {8'h00, 16'($urandom) | (16'd1 << $urandom_range(0, 15))});
    run_random(1, 1);
    wait_drain();

    // Closing stretch with no idling on either side: default prefix, and a mask that
    // accepts only the lowest and highest PDU types.
    ready_stall_pct = 0;
    send_gap_pct = 0;
    write_register(CFG_VENDOR_PREFIX, VENDOR_PREFIX_RESET);
    write_register(CFG_TYPE_MASK, {8'h00, 16'h0001 | (16'd1 << PDU_KIND_TOP)});
    run_random(1, 2);
    wait_drain();

    if (report_q.size() != 0) mismatches += report_q.size();
    $display("Run covered %0d input requests (%0d clears, %0d packets) and %0d reports,",
             requests_taken, n_clears, queued_packets, reports_checked);
    $display("with %0d filter matches over %0d register writes; %0d mismatches.",
             n_matches, n_writes, mismatches);
    if (mismatches == 0) begin
      $display("ble_adv_prefix_filter_unit regression: pass");
    end else begin
      $display("ble_adv_prefix_filter_unit regression: fail");
    end
    $finish;
  end

endmodule
